// File: sv/read_base_kmer_stats_accumulator_core_macros.svh
// Assertion macros shared by the read base k-mer statistics accumulator.
`ifndef READ_BASE_KMER_STATS_ACCUMULATOR_CORE_MACROS_SVH
`define READ_BASE_KMER_STATS_ACCUMULATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define RBK_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define RBK_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/rbk_pkg.sv
// Shared types, constants and helper functions of the read base k-mer statistics accumulator.
package rbk_pkg;

    localparam int KMER_LEN    = 7;
    localparam int COUNT_WIDTH = 32;
    localparam int SUM_WIDTH   = 48;
    localparam int WIN_BITS    = 2 * KMER_LEN;
    localparam int KDEPTH      = 1 << WIN_BITS;
    localparam int POS_W       = $clog2(KMER_LEN);
    localparam int ADDR_W      = 14;
    localparam int SCORE_W     = 16;
    localparam int CODE_W      = 3;
    localparam int NUM_CODES   = 5;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);

    localparam logic [1:0] MODE_BASE    = 2'd0;
    localparam logic [1:0] MODE_SUMMARY = 2'd1;
    localparam logic [1:0] MODE_KMER    = 2'd2;

    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_UC_A = 8'h41;
    localparam logic [7:0] CH_UC_C = 8'h43;
    localparam logic [7:0] CH_UC_G = 8'h47;
    localparam logic [7:0] CH_UC_T = 8'h54;
    localparam logic [7:0] CH_LC_A = 8'h61;
    localparam logic [7:0] CH_LC_C = 8'h63;
    localparam logic [7:0] CH_LC_G = 8'h67;
    localparam logic [7:0] CH_LC_T = 8'h74;

    localparam logic [CODE_W-1:0] CODE_A     = 3'd0;
    localparam logic [CODE_W-1:0] CODE_C     = 3'd1;
    localparam logic [CODE_W-1:0] CODE_G     = 3'd2;
    localparam logic [CODE_W-1:0] CODE_T     = 3'd3;
    localparam logic [CODE_W-1:0] CODE_OTHER = 3'd4;

    localparam logic [ADDR_W-1:0] SEL_READ_TOTAL = 14'd0;
    localparam logic [ADDR_W-1:0] SEL_LENGTH_SUM = 14'd1;
    localparam logic [ADDR_W-1:0] SEL_DUST_SUM   = 14'd2;
    localparam logic [ADDR_W-1:0] SEL_SCORE_SUM  = 14'd3;
    localparam logic [ADDR_W-1:0] SEL_TALLY_A    = 14'd4;
    localparam logic [ADDR_W-1:0] SEL_TALLY_C    = 14'd5;
    localparam logic [ADDR_W-1:0] SEL_TALLY_G    = 14'd6;
    localparam logic [ADDR_W-1:0] SEL_TALLY_T    = 14'd7;
    localparam logic [ADDR_W-1:0] SEL_TALLY_N    = 14'd8;
    localparam logic [ADDR_W-1:0] SEL_FIRST_C    = 14'd9;
    localparam logic [ADDR_W-1:0] SEL_FIRST_CT   = 14'd10;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_KMER_INC,
        OP_KMER_RD,
        OP_SUMMARY
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [WIN_BITS-1:0] index;
        logic [SUM_WIDTH-1:0] data;
    } entry_t;

    function automatic logic [CODE_W-1:0] base_code(input logic [7:0] ch);
        logic [CODE_W-1:0] code;
        case (ch)
            CH_UC_A, CH_LC_A: code = CODE_A;
            CH_UC_C, CH_LC_C: code = CODE_C;
            CH_UC_G, CH_LC_G: code = CODE_G;
            CH_UC_T, CH_LC_T: code = CODE_T;
            default:          code = CODE_OTHER;
        endcase
        return code;
    endfunction

endpackage

// File: sv/rbk_front.sv
// Front end: classifies each beat, updates the k-mer window and the read summary counters.
module rbk_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [1:0]                   mode,
    input  logic                         first_of_read,
    input  logic [7:0]                   align_char,
    input  logic [7:0]                   read_char,
    input  logic [rbk_pkg::SCORE_W-1:0]  read_score,
    input  logic [rbk_pkg::SCORE_W-1:0]  dust_value,
    input  logic [rbk_pkg::ADDR_W-1:0]   address,
    output rbk_pkg::entry_t              entry
);

    logic [rbk_pkg::WIN_BITS-1:0]    window_reg, window_next;
    logic [rbk_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic [rbk_pkg::COUNT_WIDTH-1:0] read_total_reg, read_total_next;
    logic [rbk_pkg::SUM_WIDTH-1:0]   length_sum_reg, length_sum_next;
    logic [rbk_pkg::SUM_WIDTH-1:0]   dust_sum_reg, dust_sum_next;
    logic [rbk_pkg::SUM_WIDTH-1:0]   score_sum_reg, score_sum_next;
    logic [rbk_pkg::COUNT_WIDTH-1:0] tally_reg [rbk_pkg::NUM_CODES];
    logic [rbk_pkg::COUNT_WIDTH-1:0] tally_next [rbk_pkg::NUM_CODES];
    logic [rbk_pkg::COUNT_WIDTH-1:0] first_c_reg, first_c_next;
    logic [rbk_pkg::COUNT_WIDTH-1:0] first_ct_reg, first_ct_next;

    logic [7:0]                    ref_char;
    logic [rbk_pkg::CODE_W-1:0]    code;
    logic [rbk_pkg::WIN_BITS-1:0]  win_base;
    logic [rbk_pkg::POS_W-1:0]     pos_base;
    logic [rbk_pkg::WIN_BITS-1:0]  win_shift;
    logic                          kmer_hit;
    logic                          take_base;
    logic [rbk_pkg::SUM_WIDTH-1:0] summary;
    logic                          kmer_in_range;

    always_comb
    begin
        ref_char  = (align_char == rbk_pkg::CH_DOT) ? read_char : align_char;
        code      = rbk_pkg::base_code(ref_char);
        win_base  = first_of_read ? '0 : window_reg;
        pos_base  = first_of_read ? '0 : pos_reg;
        win_shift = {win_base[rbk_pkg::WIN_BITS-3:0], 2'b00}
                    | rbk_pkg::WIN_BITS'(code);
        kmer_hit  = (pos_base >= rbk_pkg::POS_W'(rbk_pkg::KMER_LEN - 1));
        take_base = accept && (mode == rbk_pkg::MODE_BASE);
        kmer_in_range = ((address >> rbk_pkg::WIN_BITS) == '0);
    end

    always_comb
    begin
        window_next     = window_reg;
        pos_next        = pos_reg;
        read_total_next = read_total_reg;
        length_sum_next = length_sum_reg;
        dust_sum_next   = dust_sum_reg;
        score_sum_next  = score_sum_reg;
        first_c_next    = first_c_reg;
        first_ct_next   = first_ct_reg;
        for (int i = 0; i < rbk_pkg::NUM_CODES; i++)
        begin
            tally_next[i] = tally_reg[i];
        end
        if (take_base)
        begin
            if (first_of_read)
            begin
                read_total_next = read_total_reg + 1'b1;
                score_sum_next  = score_sum_reg + rbk_pkg::SUM_WIDTH'(read_score);
                dust_sum_next   = dust_sum_reg + rbk_pkg::SUM_WIDTH'(dust_value);
                if ((align_char == rbk_pkg::CH_UC_C)
                    || ((align_char == rbk_pkg::CH_DOT) && (read_char == rbk_pkg::CH_LC_C)))
                begin
                    first_c_next = first_c_reg + 1'b1;
                end
                if ((align_char == rbk_pkg::CH_UC_C) && (read_char == rbk_pkg::CH_LC_T))
                begin
                    first_ct_next = first_ct_reg + 1'b1;
                end
            end
            length_sum_next  = length_sum_reg + 1'b1;
            tally_next[code] = tally_reg[code] + 1'b1;
            window_next      = win_shift;
            pos_next         = kmer_hit ? pos_base : pos_base + 1'b1;
        end
    end

    always_comb
    begin
        case (address)
            rbk_pkg::SEL_READ_TOTAL: summary = rbk_pkg::SUM_WIDTH'(read_total_reg);
            rbk_pkg::SEL_LENGTH_SUM: summary = length_sum_reg;
            rbk_pkg::SEL_DUST_SUM:   summary = dust_sum_reg;
            rbk_pkg::SEL_SCORE_SUM:  summary = score_sum_reg;
            rbk_pkg::SEL_TALLY_A:    summary = rbk_pkg::SUM_WIDTH'(tally_reg[rbk_pkg::CODE_A]);
            rbk_pkg::SEL_TALLY_C:    summary = rbk_pkg::SUM_WIDTH'(tally_reg[rbk_pkg::CODE_C]);
            rbk_pkg::SEL_TALLY_G:    summary = rbk_pkg::SUM_WIDTH'(tally_reg[rbk_pkg::CODE_G]);
            rbk_pkg::SEL_TALLY_T:    summary = rbk_pkg::SUM_WIDTH'(tally_reg[rbk_pkg::CODE_T]);
            rbk_pkg::SEL_TALLY_N:
                summary = rbk_pkg::SUM_WIDTH'(tally_reg[rbk_pkg::CODE_OTHER]);
            rbk_pkg::SEL_FIRST_C:    summary = rbk_pkg::SUM_WIDTH'(first_c_reg);
            rbk_pkg::SEL_FIRST_CT:   summary = rbk_pkg::SUM_WIDTH'(first_ct_reg);
            default:                 summary = '0;
        endcase
    end

    always_comb
    begin
        entry.op    = rbk_pkg::OP_NONE;
        entry.index = win_shift;
        entry.data  = '0;
        case (mode)
            rbk_pkg::MODE_BASE:
            begin
                entry.op = kmer_hit ? rbk_pkg::OP_KMER_INC : rbk_pkg::OP_NONE;
            end
            rbk_pkg::MODE_SUMMARY:
            begin
                entry.op   = rbk_pkg::OP_SUMMARY;
                entry.data = summary;
            end
            rbk_pkg::MODE_KMER:
            begin
                entry.op    = kmer_in_range ? rbk_pkg::OP_KMER_RD : rbk_pkg::OP_NONE;
                entry.index = rbk_pkg::WIN_BITS'(address);
            end
            default:
            begin
                entry.op = rbk_pkg::OP_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= '0;
            pos_reg        <= '0;
            read_total_reg <= '0;
            length_sum_reg <= '0;
            dust_sum_reg   <= '0;
            score_sum_reg  <= '0;
            first_c_reg    <= '0;
            first_ct_reg   <= '0;
            for (int i = 0; i < rbk_pkg::NUM_CODES; i++)
            begin
                tally_reg[i] <= '0;
            end
        end
        else
        begin
            window_reg     <= window_next;
            pos_reg        <= pos_next;
            read_total_reg <= read_total_next;
            length_sum_reg <= length_sum_next;
            dust_sum_reg   <= dust_sum_next;
            score_sum_reg  <= score_sum_next;
            first_c_reg    <= first_c_next;
            first_ct_reg   <= first_ct_next;
            for (int i = 0; i < rbk_pkg::NUM_CODES; i++)
            begin
                tally_reg[i] <= tally_next[i];
            end
        end
    end

endmodule

// File: sv/rbk_fifo.sv
// Short queue that decouples the front end from the counter memory pipeline.
module rbk_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rbk_pkg::entry_t push_entry,
    input  logic            pop,
    output rbk_pkg::entry_t head,
    output logic            not_empty,
    output logic            not_full
);

    rbk_pkg::entry_t              slots [rbk_pkg::QDEPTH];
    logic [rbk_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [rbk_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [rbk_pkg::QPTR_W:0]     count_reg, count_next;

    always_comb
    begin
        not_empty   = (count_reg != '0);
        not_full    = (count_reg != (rbk_pkg::QPTR_W + 1)'(rbk_pkg::QDEPTH));
        head        = slots[rd_ptr_reg];
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: sv/rbk_back.sv
// Back end: k-mer counter memory with read-modify-write pipeline, clearing pass and output register.
`include "read_base_kmer_stats_accumulator_core_macros.svh"

module rbk_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rbk_pkg::entry_t              head,
    input  logic                         head_valid,
    output logic                         pop,
    output logic                         ready,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [rbk_pkg::SUM_WIDTH-1:0] out_data
);

    logic [rbk_pkg::COUNT_WIDTH-1:0] mem [rbk_pkg::KDEPTH];

    logic                            clearing_reg, clearing_next;
    logic [rbk_pkg::WIN_BITS-1:0]    clear_idx_reg, clear_idx_next;
    logic                            s1_valid_reg, s1_valid_next;
    rbk_pkg::op_t                    s1_op_reg;
    logic [rbk_pkg::WIN_BITS-1:0]    s1_index_reg;
    logic [rbk_pkg::SUM_WIDTH-1:0]   s1_data_reg;
    logic                            fwd_reg, fwd_next;
    logic [rbk_pkg::COUNT_WIDTH-1:0] fwd_data_reg;
    logic [rbk_pkg::COUNT_WIDTH-1:0] rdata_reg;
    logic                            out_valid_reg, out_valid_next;
    logic [rbk_pkg::SUM_WIDTH-1:0]   out_data_reg;

    logic                            out_free;
    logic                            s1_adv;
    logic                            s1_write;
    logic [rbk_pkg::COUNT_WIDTH-1:0] s1_count;
    logic [rbk_pkg::COUNT_WIDTH-1:0] s1_incr;
    logic [rbk_pkg::SUM_WIDTH-1:0]   s1_result;
    logic                            wr_en;
    logic [rbk_pkg::WIN_BITS-1:0]    wr_addr;
    logic [rbk_pkg::COUNT_WIDTH-1:0] wr_data;

    always_comb
    begin
        out_free = !out_valid_reg || out_ready;
        s1_adv   = s1_valid_reg && out_free;
        pop      = head_valid && !clearing_reg && (!s1_valid_reg || s1_adv);
        s1_count = fwd_reg ? fwd_data_reg : rdata_reg;
        s1_incr  = s1_count + 1'b1;
        s1_write = s1_adv && (s1_op_reg == rbk_pkg::OP_KMER_INC);
        case (s1_op_reg)
            rbk_pkg::OP_KMER_RD: s1_result = rbk_pkg::SUM_WIDTH'(s1_count);
            rbk_pkg::OP_SUMMARY: s1_result = s1_data_reg;
            default:             s1_result = '0;
        endcase
        wr_en   = clearing_reg || s1_write;
        wr_addr = clearing_reg ? clear_idx_reg : s1_index_reg;
        wr_data = clearing_reg ? '0 : s1_incr;
    end

    always_comb
    begin
        clear_idx_next = clearing_reg ? clear_idx_reg + 1'b1 : clear_idx_reg;
        clearing_next  = clearing_reg && !(&clear_idx_reg);
        s1_valid_next  = pop ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        fwd_next       = pop ? (s1_write && (head.index == s1_index_reg)) : fwd_reg;
        out_valid_next = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (pop)
        begin
            rdata_reg    <= mem[head.index];
            fwd_data_reg <= s1_incr;
            s1_op_reg    <= head.op;
            s1_index_reg <= head.index;
            s1_data_reg  <= head.data;
        end
        if (s1_adv)
        begin
            out_data_reg <= s1_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clear_idx_reg <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clear_idx_reg <= clear_idx_next;
            s1_valid_reg  <= s1_valid_next;
            fwd_reg       <= fwd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign ready     = !clearing_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `RBK_ASSERT_IMPL(a_idle_while_clearing, clearing_reg, !s1_valid_reg && !out_valid_reg, "counter pipeline busy during clearing pass")
    `RBK_ASSERT_NEXT(a_fwd_on_hazard, pop && s1_write && (head.index == s1_index_reg), fwd_reg, "missed forward of a counter being written")
    `RBK_ASSERT_NEXT(a_s1_holds_on_stall, s1_valid_reg && !s1_adv, s1_valid_reg, "stalled counter stage lost its beat")

endmodule

// File: sv/read_base_kmer_stats_accumulator_core.sv
// Top level of the read base k-mer statistics accumulator: stream ports, front end, queue, back end.
// Throughput: one beat per cycle in and one result per cycle out while m_axis_tready is high.
// A beat passes through the queue slot, the stage-1 registers and the output register.
// The counter memory read-modify-write is pipelined with one-deep forwarding between beats.
// After reset a clearing pass zeroes the 16384 k-mer counters, one per cycle.
// All other counters clear at reset; s_axis_tready stays low until the clearing pass ends.
module read_base_kmer_stats_accumulator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // first_of_read[0], align_char[8:1], read_char[16:9], read_score[32:17],
    // dust_value[48:33], address[62:49], zero[63]
    input  logic [63:0] s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[47:0]
    output logic [47:0] m_axis_tdata
);

    logic            accept;
    rbk_pkg::entry_t front_entry;
    rbk_pkg::entry_t head;
    logic            head_valid;
    logic            q_not_full;
    logic            pop;
    logic            back_ready;

    assign s_axis_tready = q_not_full && back_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    rbk_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .mode          (s_axis_tuser),
        .first_of_read (s_axis_tdata[0]),
        .align_char    (s_axis_tdata[8:1]),
        .read_char     (s_axis_tdata[16:9]),
        .read_score    (s_axis_tdata[32:17]),
        .dust_value    (s_axis_tdata[48:33]),
        .address       (s_axis_tdata[62:49]),
        .entry         (front_entry)
    );

    rbk_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_entry (front_entry),
        .pop        (pop),
        .head       (head),
        .not_empty  (head_valid),
        .not_full   (q_not_full)
    );

    rbk_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .ready      (back_ready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata)
    );

endmodule
